[rtl/cbdc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the cubic Bezier point evaluator.
// No dependencies.
package cbdc_pkg;

  localparam int unsigned COORD_BITS_DEF      = 10;
  localparam int unsigned PARAM_FRAC_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_BITS        = 4;
  localparam int unsigned NUM_POINTS          = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_P0_X = 4'd0,
    REG_P0_Y = 4'd1,
    REG_P1_X = 4'd2,
    REG_P1_Y = 4'd3,
    REG_P2_X = 4'd4,
    REG_P2_Y = 4'd5,
    REG_P3_X = 4'd6,
    REG_P3_Y = 4'd7
  } reg_idx_e;

  // per-stage load enables of the interpolation pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

[rtl/cbdc_cfg_regs.sv]
`timescale 1ns / 1ps
// Control point register file, written through the configuration channel.
// Depends on cbdc_pkg.
module cbdc_cfg_regs #(
  parameter int unsigned COORD_BITS = cbdc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [cbdc_pkg::CFG_IDX_BITS-1:0] wr_index_i,
  input  logic [COORD_BITS-1:0]             wr_data_i,
  output logic [COORD_BITS-1:0]             px_o [cbdc_pkg::NUM_POINTS],
  output logic [COORD_BITS-1:0]             py_o [cbdc_pkg::NUM_POINTS]
);

  logic [COORD_BITS-1:0] px_q [cbdc_pkg::NUM_POINTS];
  logic [COORD_BITS-1:0] py_q [cbdc_pkg::NUM_POINTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cbdc_pkg::NUM_POINTS; i++) begin
        px_q[i] <= '0;
        py_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      unique case (cbdc_pkg::reg_idx_e'(wr_index_i))
        cbdc_pkg::REG_P0_X: px_q[0] <= wr_data_i;
        cbdc_pkg::REG_P0_Y: py_q[0] <= wr_data_i;
        cbdc_pkg::REG_P1_X: px_q[1] <= wr_data_i;
        cbdc_pkg::REG_P1_Y: py_q[1] <= wr_data_i;
        cbdc_pkg::REG_P2_X: px_q[2] <= wr_data_i;
        cbdc_pkg::REG_P2_Y: py_q[2] <= wr_data_i;
        cbdc_pkg::REG_P3_X: px_q[3] <= wr_data_i;
        cbdc_pkg::REG_P3_Y: py_q[3] <= wr_data_i;
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

  assign px_o = px_q;
  assign py_o = py_q;

endmodule

[rtl/cbdc_lerp.sv]
`timescale 1ns / 1ps
// One fixed-point interpolation step: (a*ONE + t*(b-a)) >> FRAC, exact.
// No dependencies.
module cbdc_lerp #(
  parameter int unsigned VAL_BITS  = 26,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic [VAL_BITS-1:0]  a_i,
  input  logic [VAL_BITS-1:0]  b_i,
  input  logic [FRAC_BITS:0]   t_i,
  output logic [VAL_BITS-1:0]  p_o
);

  localparam int unsigned PW = VAL_BITS + FRAC_BITS + 3;

  logic signed [VAL_BITS:0]    diff;
  logic signed [FRAC_BITS+1:0] ts;
  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        base;
  logic signed [PW-1:0]        sum;

  always_comb begin
    diff = $signed({1'b0, b_i}) - $signed({1'b0, a_i});
    ts   = $signed({1'b0, t_i});
    prod = PW'(ts) * PW'(diff);
    base = $signed({3'b000, a_i, {FRAC_BITS{1'b0}}});
    sum  = base + prod;
  end

  // convex combination: sum is never negative and fits VAL_BITS after the shift
  assign p_o = sum[FRAC_BITS +: VAL_BITS];

endmodule

[rtl/cbdc_axis_pipe.sv]
`timescale 1ns / 1ps
// Three-stage de Casteljau pipeline for one axis.
// Depends on cbdc_pkg and cbdc_lerp.
module cbdc_axis_pipe #(
  parameter int unsigned COORD_BITS      = cbdc_pkg::COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = cbdc_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  cbdc_pkg::pipe_en_t         en_i,
  input  logic [COORD_BITS-1:0]      c_i [cbdc_pkg::NUM_POINTS],
  input  logic [PARAM_FRAC_BITS:0]   t0_i,
  input  logic [PARAM_FRAC_BITS:0]   t1_i,
  input  logic [PARAM_FRAC_BITS:0]   t2_i,
  output logic [COORD_BITS-1:0]      pix_o
);

  localparam int unsigned VW = COORD_BITS + PARAM_FRAC_BITS;

  logic [VW-1:0] p [cbdc_pkg::NUM_POINTS];
  logic [VW-1:0] q_d [3];
  logic [VW-1:0] q_q [3];
  logic [VW-1:0] r_d [2];
  logic [VW-1:0] r_q [2];
  logic [VW-1:0] s_d;
  logic [COORD_BITS-1:0] pix_q;

  always_comb begin
    for (int i = 0; i < cbdc_pkg::NUM_POINTS; i++) begin
      p[i] = {c_i[i], {PARAM_FRAC_BITS{1'b0}}};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lvl1
    cbdc_lerp #(.VAL_BITS(VW), .FRAC_BITS(PARAM_FRAC_BITS)) u_lerp (
      .a_i(p[i]), .b_i(p[i+1]), .t_i(t0_i), .p_o(q_d[i])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_lvl2
    cbdc_lerp #(.VAL_BITS(VW), .FRAC_BITS(PARAM_FRAC_BITS)) u_lerp (
      .a_i(q_q[i]), .b_i(q_q[i+1]), .t_i(t1_i), .p_o(r_d[i])
    );
  end

  cbdc_lerp #(.VAL_BITS(VW), .FRAC_BITS(PARAM_FRAC_BITS)) u_lerp3 (
    .a_i(r_q[0]), .b_i(r_q[1]), .t_i(t2_i), .p_o(s_d)
  );

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      q_q <= q_d;
    end
    if (en_i.s2) begin
      r_q <= r_d;
    end
    if (en_i.s3) begin
      pix_q <= s_d[PARAM_FRAC_BITS +: COORD_BITS];
    end
  end

  assign pix_o = pix_q;

endmodule

[rtl/cubic_bezier_de_casteljau_point.sv]
`timescale 1ns / 1ps
// Cubic Bezier point evaluator, top level: config registers, pipeline control, two axes.
// Depends on cbdc_pkg, cbdc_cfg_regs, cbdc_axis_pipe.
//
// Usage:
//   Configuration: write control point coordinates on cfg_valid_i/cfg_ready_o with
//   cfg_index_i (0..7: p0.x, p0.y, p1.x, ... p3.y) and cfg_data_i. cfg_ready_o is
//   always high; indexes beyond 7 are dropped. Write only while the pipeline is empty.
//   Input: one item is the curve parameter t (Q1.16, 65536 = 1.0; larger values
//   clamp to 1.0), taken when in_valid_i is high and in_stall_o is low.
//   Output: pixel_x_o/pixel_y_o, the truncated curve point, handed over when
//   out_valid_o is high and out_stall_i is low.
//   Pipeline: an accepted item passes each stage in turn to out_valid_o, one interpolation level
//   per stage (one multiply and add per lerp). Throughput: one item per cycle unless in_stall_o is high.
//   Stall: a stalled output holds; empty stages still fill, so in_stall_o rises
//   only when all three stages hold items and out_stall_i is high.
//   Reset: all control points read 0 and the pipeline is empty.
module cubic_bezier_de_casteljau_point #(
  parameter int unsigned COORD_BITS      = cbdc_pkg::COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = cbdc_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cbdc_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [PARAM_FRAC_BITS:0]          curve_param_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [COORD_BITS-1:0]             pixel_x_o,
  output logic [COORD_BITS-1:0]             pixel_y_o
);

  localparam logic [PARAM_FRAC_BITS:0] T_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

  logic [COORD_BITS-1:0] px [cbdc_pkg::NUM_POINTS];
  logic [COORD_BITS-1:0] py [cbdc_pkg::NUM_POINTS];

  logic v1_q, v2_q, v3_q;
  logic v1_d, v2_d, v3_d;
  logic rdy1, rdy2, rdy3;
  logic [PARAM_FRAC_BITS:0] t0, t1_q, t2_q;
  cbdc_pkg::pipe_en_t en;

  assign cfg_ready_o = 1'b1;

  cbdc_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .px_o       (px),
    .py_o       (py)
  );

  assign t0 = (curve_param_i > T_ONE) ? T_ONE : curve_param_i;

  always_comb begin
    rdy3 = !v3_q || !out_stall_i;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    en.s1 = rdy1;
    en.s2 = rdy2;
    en.s3 = rdy3;
    v1_d = rdy1 ? in_valid_i : v1_q;
    v2_d = rdy2 ? v1_q : v2_q;
    v3_d = rdy3 ? v2_q : v3_q;
  end

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      t1_q <= t0;
    end
    if (en.s2) begin
      t2_q <= t1_q;
    end
  end

  cbdc_axis_pipe #(
    .COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_axis_x (
    .clk_i (clk_i), .en_i (en), .c_i (px),
    .t0_i (t0), .t1_i (t1_q), .t2_i (t2_q), .pix_o (pixel_x_o)
  );

  cbdc_axis_pipe #(
    .COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_axis_y (
    .clk_i (clk_i), .en_i (en), .c_i (py),
    .t0_i (t0), .t1_i (t1_q), .t2_i (t2_q), .pix_o (pixel_y_o)
  );

  assign out_valid_o = v3_q;

endmodule

[rtl/cbdc_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the Bezier point evaluator, bound to the top level.
// Depends on cbdc_pkg and cubic_bezier_de_casteljau_point.
module cbdc_checker #(
  parameter int unsigned COORD_BITS      = cbdc_pkg::COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = cbdc_pkg::PARAM_FRAC_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [PARAM_FRAC_BITS:0]          curve_param_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [COORD_BITS-1:0]             pixel_x_o,
  input logic [COORD_BITS-1:0]             pixel_y_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(curve_param_i)))
    else $error("stalled input item changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(pixel_x_o) && $stable(pixel_y_o)))
    else $error("stalled output item changed");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("item did not reach output in three cycles");

endmodule

bind cubic_bezier_de_casteljau_point cbdc_checker #(
  .COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
) u_cbdc_checker (.*);
